[hw/rtl/cartesian_to_spherical_velocity_top_assert.svh]
// assertion macros for the velocity rotation block
`ifndef CARTESIAN_TO_SPHERICAL_VELOCITY_TOP_ASSERT_SVH
`define CARTESIAN_TO_SPHERICAL_VELOCITY_TOP_ASSERT_SVH

// when a holds, b holds in the same cycle
`define C2SV_ASSERT_NOW(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("c2sv assertion failed");

// when a holds, b holds in the next cycle
`define C2SV_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("c2sv assertion failed");

`endif

[hw/rtl/c2sv_pkg.sv]
`timescale 1ns / 1ps
package c2sv_pkg;
   localparam int VEL_WIDTH    = 32;
   localparam int ANGLE_WIDTH  = 24;
   localparam int CORDIC_STEPS = 24;
   localparam int TRIG_WIDTH   = 32;
   localparam int CORDIC_WIDTH = 34;
   localparam int PHASE_SHIFT  = 32 - ANGLE_WIDTH;

   localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = CORDIC_WIDTH'(64'sd652032874);
   localparam logic signed [CORDIC_WIDTH-1:0] TRIG_ONE    = CORDIC_WIDTH'(64'sd1073741824);

   localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
      32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   typedef struct packed {
      logic signed [VEL_WIDTH-1:0]   vel_x;
      logic signed [VEL_WIDTH-1:0]   vel_y;
      logic signed [VEL_WIDTH-1:0]   vel_z;
      logic signed [ANGLE_WIDTH-1:0] longitude;
      logic signed [ANGLE_WIDTH-1:0] latitude;
   } req_type;

   typedef struct packed {
      logic signed [VEL_WIDTH-1:0] vel_radial;
      logic signed [VEL_WIDTH-1:0] vel_east;
      logic signed [VEL_WIDTH-1:0] vel_north;
   } rsp_type;

   typedef struct packed {
      logic signed [TRIG_WIDTH-1:0] sin_val;
      logic signed [TRIG_WIDTH-1:0] cos_val;
   } trig_type;
endpackage

[hw/rtl/cartesian_to_spherical_velocity_top.sv]
`timescale 1ns / 1ps
// Rotates a Cartesian velocity into radial, east and north components at the point's
// longitude and latitude, or passes it through (east=x, north=y, radial=z) when
// cartesian_mode is set. Fully pipelined: one item per cycle; between acceptance and
// rsp_valid lie the 24 unrolled CORDIC stages plus sign fold, clamp, trig product,
// rounding, velocity product, sum and saturation stages. A stall on rsp_ready freezes
// the whole pipeline. Write cartesian_mode only while idle.
module cartesian_to_spherical_velocity_top
   import c2sv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_wdata
);
   `include "cartesian_to_spherical_velocity_top_assert.svh"

   localparam int STAGES  = CORDIC_STEPS + 7;
   localparam int ST_TRIG = CORDIC_STEPS + 1;
   localparam int ST_MUL  = CORDIC_STEPS + 4;
   localparam int ST_SUM  = CORDIC_STEPS + 5;
   localparam int LAST    = STAGES - 1;
   localparam int PH_W    = VEL_WIDTH - 16 + TRIG_WIDTH;
   localparam int PL_W    = 17 + TRIG_WIDTH;
   localparam int HS_W    = PH_W + 2;
   localparam int LS_W    = PL_W + 2;
   localparam int RS_W    = HS_W + 1;
   localparam int RQ_W    = RS_W - 14;

   logic    enable;
   logic    mode_ff;
   logic    vld_ff [STAGES];
   req_type pipe_ff [LAST];

   trig_type lon_trig;
   trig_type lat_trig;
   trig_type lon_ff;
   trig_type lat_ff;

   logic signed [2*TRIG_WIDTH-1:0] cc_ff, sc_ff, cs_ff, ss_ff;
   logic signed [TRIG_WIDTH-1:0]   coef_in [3][3];
   logic signed [TRIG_WIDTH-1:0]   coef_ff [3][3];
   logic signed [PH_W-1:0]         ph_in [3][3];
   logic signed [PL_W-1:0]         pl_in [3][3];
   logic signed [PH_W-1:0]         ph_ff [3][3];
   logic signed [PL_W-1:0]         pl_ff [3][3];
   logic signed [HS_W-1:0]         hs_ff [3];
   logic signed [LS_W-1:0]         ls_ff [3];
   logic signed [VEL_WIDTH-1:0]    res_in [3];
   logic signed [VEL_WIDTH-1:0]    vel_m [3];
   rsp_type                        out_in;
   rsp_type                        out_ff;

   function automatic logic signed [TRIG_WIDTH-1:0] round_q30(
      input logic signed [2*TRIG_WIDTH-1:0] p);
      logic signed [2*TRIG_WIDTH-1:0] t;
      t = (p + (2*TRIG_WIDTH)'(64'sd536870912)) >>> 30;
      return TRIG_WIDTH'(t);
   endfunction

   function automatic logic signed [VEL_WIDTH-1:0] finish(
      input logic signed [HS_W-1:0] hs,
      input logic signed [LS_W-1:0] ls);
      logic signed [RS_W-1:0] t;
      logic signed [RQ_W-1:0] r;
      logic signed [VEL_WIDTH-1:0] res;
      t = RS_W'(hs) + RS_W'(ls >>> 16) + RS_W'(64'sd8192);
      r = RQ_W'(t >>> 14);
      res = r[VEL_WIDTH-1:0];
      // saturate when the bits above the result are not a sign extension
      if (r[RQ_W-1:VEL_WIDTH-1] != {(RQ_W-VEL_WIDTH+1){r[RQ_W-1]}}) begin
         res = r[RQ_W-1] ? {1'b1, {(VEL_WIDTH-1){1'b0}}} : {1'b0, {(VEL_WIDTH-1){1'b1}}};
      end
      return res;
   endfunction

   assign enable    = !vld_ff[LAST] || rsp_ready;
   assign req_ready = enable;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         mode_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) vld_ff[i] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < STAGES; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pipe_ff[0] <= req_data;
         for (int i = 1; i < LAST; i++) pipe_ff[i] <= pipe_ff[i-1];
      end
   end

   c2sv_cordic u_lon (
      .clock  (clock),
      .enable (enable),
      .angle  (req_data.longitude),
      .trig   (lon_trig)
   );

   c2sv_cordic u_lat (
      .clock  (clock),
      .enable (enable),
      .angle  (req_data.latitude),
      .trig   (lat_trig)
   );

   // trig products
   always_ff @(posedge clock) begin
      if (enable) begin
         lon_ff <= lon_trig;
         lat_ff <= lat_trig;
         cc_ff  <= (2*TRIG_WIDTH)'(lon_trig.cos_val) * (2*TRIG_WIDTH)'(lat_trig.cos_val);
         sc_ff  <= (2*TRIG_WIDTH)'(lon_trig.sin_val) * (2*TRIG_WIDTH)'(lat_trig.cos_val);
         cs_ff  <= (2*TRIG_WIDTH)'(lon_trig.cos_val) * (2*TRIG_WIDTH)'(lat_trig.sin_val);
         ss_ff  <= (2*TRIG_WIDTH)'(lon_trig.sin_val) * (2*TRIG_WIDTH)'(lat_trig.sin_val);
      end
   end

   // rotation matrix rows: radial, east, north
   always_comb begin
      coef_in[0][0] = round_q30(cc_ff);
      coef_in[0][1] = round_q30(sc_ff);
      coef_in[0][2] = lat_ff.sin_val;
      coef_in[1][0] = -lon_ff.sin_val;
      coef_in[1][1] = lon_ff.cos_val;
      coef_in[1][2] = '0;
      coef_in[2][0] = -round_q30(cs_ff);
      coef_in[2][1] = -round_q30(ss_ff);
      coef_in[2][2] = lat_ff.cos_val;
   end

   always_ff @(posedge clock) begin
      if (enable) coef_ff <= coef_in;
   end

   // velocity split into signed high part and unsigned low 16 bits
   always_comb begin
      vel_m[0] = pipe_ff[ST_MUL-1].vel_x;
      vel_m[1] = pipe_ff[ST_MUL-1].vel_y;
      vel_m[2] = pipe_ff[ST_MUL-1].vel_z;
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            ph_in[k][j] = PH_W'(vel_m[j] >>> 16) * PH_W'(coef_ff[k][j]);
            pl_in[k][j] = PL_W'(signed'({1'b0, vel_m[j][15:0]})) * PL_W'(coef_ff[k][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ph_ff <= ph_in;
         pl_ff <= pl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            hs_ff[k] <= HS_W'(ph_ff[k][0]) + HS_W'(ph_ff[k][1]) + HS_W'(ph_ff[k][2]);
            ls_ff[k] <= LS_W'(pl_ff[k][0]) + LS_W'(pl_ff[k][1]) + LS_W'(pl_ff[k][2]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) res_in[k] = finish(hs_ff[k], ls_ff[k]);
      if (mode_ff) begin
         out_in.vel_radial = pipe_ff[ST_SUM].vel_z;
         out_in.vel_east   = pipe_ff[ST_SUM].vel_x;
         out_in.vel_north  = pipe_ff[ST_SUM].vel_y;
      end else begin
         out_in.vel_radial = res_in[0];
         out_in.vel_east   = res_in[1];
         out_in.vel_north  = res_in[2];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) out_ff <= out_in;
   end

   assign rsp_valid = vld_ff[LAST];
   assign rsp_data  = out_ff;

   `C2SV_ASSERT_NOW(a_stall_only_on_held_output, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   `C2SV_ASSERT_NEXT(a_accept_enters_pipe, clock, reset, req_valid && req_ready, vld_ff[0])
   `C2SV_ASSERT_NEXT(a_stall_freezes_trig, clock, reset, !req_ready, vld_ff[ST_TRIG] == $past(vld_ff[ST_TRIG]))
endmodule

[hw/rtl/c2sv_cordic.sv]
`timescale 1ns / 1ps
module c2sv_cordic
   import c2sv_pkg::*;
(
   input  logic                          clock,
   input  logic                          enable,
   input  logic signed [ANGLE_WIDTH-1:0] angle,
   output trig_type                      trig
);
   logic [31:0] phase;
   logic [31:0] phase_folded;
   logic        flip;

   logic signed [CORDIC_WIDTH-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [CORDIC_WIDTH-1:0] y_ff [CORDIC_STEPS+1];
   logic signed [CORDIC_WIDTH-1:0] z_ff [CORDIC_STEPS+1];
   logic                           flip_ff [CORDIC_STEPS+1];

   logic signed [CORDIC_WIDTH-1:0] cos_fix;
   logic signed [CORDIC_WIDTH-1:0] sin_fix;
   trig_type                       trig_in;
   trig_type                       trig_ff;

   function automatic logic signed [TRIG_WIDTH-1:0] clamp_trig(
      input logic signed [CORDIC_WIDTH-1:0] v);
      logic signed [CORDIC_WIDTH-1:0] c;
      c = v;
      if (v > TRIG_ONE) c = TRIG_ONE;
      else if (v < -TRIG_ONE) c = -TRIG_ONE;
      return TRIG_WIDTH'(c);
   endfunction

   // fold the left half plane onto the right, undone by negation at the end
   always_comb begin
      phase        = 32'(unsigned'(angle)) << PHASE_SHIFT;
      flip         = phase[31] ^ phase[30];
      phase_folded = flip ? (phase ^ 32'h80000000) : phase;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= CORDIC_WIDTH'(signed'(phase_folded));
         flip_ff[0] <= flip;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][CORDIC_WIDTH-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - CORDIC_WIDTH'(ATAN_TURNS[i]);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + CORDIC_WIDTH'(ATAN_TURNS[i]);
            end
         end
      end
   end

   always_comb begin
      cos_fix = flip_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
      sin_fix = flip_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
      trig_in.cos_val = clamp_trig(cos_fix);
      trig_in.sin_val = clamp_trig(sin_fix);
   end

   always_ff @(posedge clock) begin
      if (enable) trig_ff <= trig_in;
   end

   assign trig = trig_ff;
endmodule
